/* design/mi4_pkg.sv */
// Shared types, sequencer states and the cofactor term table for the 4x4 inverse.
`default_nettype none
package mi4_pkg;

    typedef enum logic [3:0] {
        S_LOAD,
        S_T0,
        S_T1,
        S_T2,
        S_M1,
        S_M2,
        S_D0,
        S_D1,
        S_DM,
        S_CHK,
        S_O0,
        S_O1,
        S_DV,
        S_OUT
    } t_state;

    // One product term of a 3x3 minor: three store addresses and its sign.
    typedef struct packed {
        logic [3:0] ix;
        logic [3:0] iy;
        logic [3:0] iz;
        logic       neg;
    } t_term;

    localparam int NUM_TERMS = 6;

    // Term p of cofactor (r, c), with the checkerboard sign folded in.
    function automatic t_term term_of(input logic [3:0] cidx, input logic [2:0] p);
        logic [1:0] rr [3];
        logic [1:0] cc [3];
        logic [1:0] s0, s1, s2;
        logic       psgn;
        int         nr, nc, i;
        t_term      t;
        nr = 0;
        nc = 0;
        for (i = 0; i < 3; i++) begin
            rr[i] = 2'd0;
            cc[i] = 2'd0;
        end
        for (i = 0; i < 4; i++) begin
            if (2'(i) != cidx[3:2] && nr < 3) begin
                rr[nr] = 2'(i);
                nr++;
            end
            if (2'(i) != cidx[1:0] && nc < 3) begin
                cc[nc] = 2'(i);
                nc++;
            end
        end
        case (p)
            3'd0: begin s0 = 2'd0; s1 = 2'd1; s2 = 2'd2; psgn = 1'b0; end
            3'd1: begin s0 = 2'd1; s1 = 2'd2; s2 = 2'd0; psgn = 1'b0; end
            3'd2: begin s0 = 2'd2; s1 = 2'd0; s2 = 2'd1; psgn = 1'b0; end
            3'd3: begin s0 = 2'd0; s1 = 2'd2; s2 = 2'd1; psgn = 1'b1; end
            3'd4: begin s0 = 2'd2; s1 = 2'd1; s2 = 2'd0; psgn = 1'b1; end
            default: begin s0 = 2'd1; s1 = 2'd0; s2 = 2'd2; psgn = 1'b1; end
        endcase
        t.ix  = {rr[0], cc[s0]};
        t.iy  = {rr[1], cc[s1]};
        t.iz  = {rr[2], cc[s2]};
        t.neg = psgn ^ cidx[2] ^ cidx[0];
        return t;
    endfunction

endpackage
`default_nettype wire

/* design/mi4_mul.sv */
// Shift-add signed multiplier: wide operand times one element, one bit per cycle.
`default_nettype none
module mi4_mul #(
    parameter int WW = 136,
    parameter int EW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [WW-1:0] i_a,
    input  wire logic [EW-1:0] i_b,
    output logic               o_done,
    output logic [WW-1:0]      o_p
);
    localparam int CW = $clog2(EW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [WW-1:0] r_a;
    logic [EW-1:0] r_b;
    logic [WW-1:0] r_p;
    logic          last;
    logic [WW-1:0] addend;

    assign last = (r_cnt == CW'(EW - 1));
    // Top bit of a two's complement multiplier carries negative weight.
    always_comb begin
        if (!r_b[0])
            addend = '0;
        else if (last)
            addend = WW'(0) - r_a;
        else
            addend = r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_p    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_p   <= r_p + addend;
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + CW'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule
`default_nettype wire

/* design/mi4_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module mi4_div #(
    parameter int WW = 136
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [WW-1:0] i_num,
    input  wire logic [WW-1:0] i_den,
    output logic               o_done,
    output logic [WW-1:0]      o_q
);
    localparam int CW = $clog2(WW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [WW-1:0] r_num;
    logic [WW-1:0] r_den;
    logic [WW-1:0] r_rem;
    logic [WW-1:0] r_q;
    logic [WW:0]   rem_sh;
    logic [WW:0]   diff;
    logic          ge;

    assign rem_sh = {r_rem, r_num[WW-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // remainder stays below the divisor, so WW bits hold it
                r_rem <= ge ? diff[WW-1:0] : rem_sh[WW-1:0];
                r_q   <= {r_q[WW-2:0], ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(WW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
`default_nettype wire

/* design/matrix4_inverse.sv */
// 4x4 fixed-point matrix inverse by exact cofactors, shared multiplier and divider.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  input    | i_valid / o_stall      | i_element
//  output   | o_valid / i_stall      | o_result_element, o_result_index, o_determinant,
//           |                        | o_singular, o_saturated, o_last
//  config   | i_cfg_wr_en            | i_cfg_data (singular threshold)
//
// Elements load one per cycle while o_stall is low; after the sixteenth, 96 cofactor terms
// take two serial multiplies apiece, the determinant 4 more multiplies, then each of
// 16 results a divide (no divide when singular).
// Synchronous active-low reset clears the sequencer; threshold resets to 1.
// A stalled result holds; the input side stays stalled until all 16 are taken.
`default_nettype none
module matrix4_inverse #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [ELEM_WIDTH-1:0] i_element,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [ELEM_WIDTH-1:0]      o_result_element,
    output logic [3:0]                        o_result_index,
    output logic signed [63:0]                o_determinant,
    output logic                              o_singular,
    output logic                              o_saturated,
    output logic                              o_last,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [15:0]                  i_cfg_data
);
    localparam int EW  = ELEM_WIDTH;
    localparam int WA  = 4 * EW + 4;
    localparam int WB  = 3 * EW + 2 * FRAC_BITS + 2;
    localparam int WC  = 3 * FRAC_BITS + 18;
    localparam int WAB = (WA > WB) ? WA : WB;
    localparam int WW  = (WAB > WC) ? WAB : WC;

    mi4_pkg::t_state r_state, n_state;
    logic [3:0]      r_load_cnt, n_load_cnt;
    logic [3:0]      r_cidx, n_cidx;
    logic [2:0]      r_term, n_term;
    logic [3:0]      r_k, n_k;
    logic [WW-1:0]   r_acc, n_acc;
    logic [WW-1:0]   r_det, n_det;
    logic [WW-1:0]   r_magd, n_magd;
    logic            r_sing, n_sing;
    logic            r_qneg, n_qneg;
    logic [63:0]     r_detout, n_detout;
    logic [15:0]     r_thr;
    logic [EW-1:0]   r_x, n_x;

    logic            r_ovalid, n_ovalid;
    logic [EW-1:0]   r_oelem, n_oelem;
    logic            r_osat, n_osat;

    logic [EW-1:0]   mem [16];
    logic [EW-1:0]   r_rd;
    logic [3:0]      rd_addr;
    logic            rd_en;
    logic            wr_en;

    logic [WW-1:0]   cof_mem [16];
    logic [WW-1:0]   r_cof_rd;
    logic [3:0]      cof_raddr;
    logic            cof_we;

    mi4_pkg::t_term  term;
    logic            mul_start;
    logic [WW-1:0]   mul_a;
    logic [EW-1:0]   mul_b;
    logic            mul_done;
    logic [WW-1:0]   mul_p;
    logic            div_start;
    logic [WW-1:0]   div_num;
    logic            div_done;
    logic [WW-1:0]   div_q;

    logic [WW-1:0]   acc_new;
    logic [WW-1:0]   magd_c;
    logic [WW-1:0]   thr_w;
    logic [WW-1:0]   dshift;
    logic [WW-1:0]   dlim;
    logic [WW-1:0]   dval;
    logic [WW-1:0]   cof_abs;
    logic [WW-1:0]   qlim;
    logic [WW-1:0]   qval;
    logic            qover;

    assign term    = mi4_pkg::term_of(r_cidx, r_term);
    assign acc_new = term.neg ? (r_acc - mul_p) : (r_acc + mul_p);

    assign wr_en = (r_state == mi4_pkg::S_LOAD) && i_valid;
    assign rd_en = (r_state == mi4_pkg::S_T0) || (r_state == mi4_pkg::S_T1) ||
                   (r_state == mi4_pkg::S_T2) || (r_state == mi4_pkg::S_D0);
    always_comb begin
        case (r_state)
            mi4_pkg::S_T0: rd_addr = term.ix;
            mi4_pkg::S_T1: rd_addr = term.iy;
            mi4_pkg::S_T2: rd_addr = term.iz;
            default:       rd_addr = {2'b00, r_cidx[1:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en)
            mem[r_load_cnt] <= i_element;
        if (rd_en)
            r_rd <= mem[rd_addr];
    end

    // cofactor of (i, j) sits at i*4+j; result k = i*4+j needs cofactor (j, i)
    assign cof_raddr = (r_state == mi4_pkg::S_O0) ? {r_k[1:0], r_k[3:2]}
                                                  : {2'b00, r_cidx[1:0]};
    assign cof_we    = (r_state == mi4_pkg::S_M2) && mul_done &&
                       (r_term == 3'(mi4_pkg::NUM_TERMS - 1));

    always_ff @(posedge i_clk) begin
        if (cof_we)
            cof_mem[r_cidx] <= acc_new;
        r_cof_rd <= cof_mem[cof_raddr];
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_start = 1'b0;
        mul_a     = mul_p;
        mul_b     = r_rd;
        case (r_state)
            mi4_pkg::S_T2: begin
                mul_start = 1'b1;
                mul_a     = WW'($signed(r_x));
            end
            mi4_pkg::S_M1: mul_start = mul_done;
            mi4_pkg::S_D1: begin
                mul_start = 1'b1;
                mul_a     = r_cof_rd;
            end
            default: mul_start = 1'b0;
        endcase
    end

    assign cof_abs   = r_cof_rd[WW-1] ? (WW'(0) - r_cof_rd) : r_cof_rd;
    assign div_num   = cof_abs << (2 * FRAC_BITS);
    assign div_start = (r_state == mi4_pkg::S_O1) && !r_sing;

    mi4_mul #(.WW(WW), .EW(EW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    mi4_div #(.WW(WW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_magd),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // determinant checks
    assign magd_c = r_det[WW-1] ? (WW'(0) - r_det) : r_det;
    assign thr_w  = WW'(r_thr) << (3 * FRAC_BITS);
    assign dshift = magd_c >> (2 * FRAC_BITS);
    assign dlim   = (WW'(1) << 63) - (r_det[WW-1] ? WW'(0) : WW'(1));
    assign dval   = (dshift > dlim) ? dlim : dshift;

    // quotient saturation
    assign qlim  = (WW'(1) << (EW - 1)) - (r_qneg ? WW'(0) : WW'(1));
    assign qover = (div_q > qlim);
    assign qval  = qover ? qlim : div_q;

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_cidx     = r_cidx;
        n_term     = r_term;
        n_k        = r_k;
        n_acc      = r_acc;
        n_det      = r_det;
        n_magd     = r_magd;
        n_sing     = r_sing;
        n_qneg     = r_qneg;
        n_detout   = r_detout;
        n_x        = r_x;
        n_ovalid   = r_ovalid;
        n_oelem    = r_oelem;
        n_osat     = r_osat;
        case (r_state)
            mi4_pkg::S_LOAD: begin
                if (i_valid) begin
                    n_load_cnt = r_load_cnt + 4'd1;
                    if (r_load_cnt == 4'd15) begin
                        n_cidx  = '0;
                        n_term  = '0;
                        n_acc   = '0;
                        n_det   = '0;
                        n_state = mi4_pkg::S_T0;
                    end
                end
            end
            mi4_pkg::S_T0: n_state = mi4_pkg::S_T1;
            mi4_pkg::S_T1: begin
                n_x     = r_rd;
                n_state = mi4_pkg::S_T2;
            end
            mi4_pkg::S_T2: n_state = mi4_pkg::S_M1;
            mi4_pkg::S_M1: begin
                if (mul_done)
                    n_state = mi4_pkg::S_M2;
            end
            mi4_pkg::S_M2: begin
                if (mul_done) begin
                    if (r_term == 3'(mi4_pkg::NUM_TERMS - 1)) begin
                        n_acc  = '0;
                        n_term = '0;
                        n_cidx = r_cidx + 4'd1;
                        n_state = (r_cidx == 4'd15) ? mi4_pkg::S_D0 : mi4_pkg::S_T0;
                    end else begin
                        n_acc   = acc_new;
                        n_term  = r_term + 3'd1;
                        n_state = mi4_pkg::S_T0;
                    end
                end
            end
            mi4_pkg::S_D0: n_state = mi4_pkg::S_D1;
            mi4_pkg::S_D1: n_state = mi4_pkg::S_DM;
            mi4_pkg::S_DM: begin
                if (mul_done) begin
                    n_det  = r_det + mul_p;
                    n_cidx = r_cidx + 4'd1;
                    n_state = (r_cidx[1:0] == 2'd3) ? mi4_pkg::S_CHK : mi4_pkg::S_D0;
                end
            end
            mi4_pkg::S_CHK: begin
                n_magd   = magd_c;
                n_sing   = (magd_c == '0) || (magd_c < thr_w);
                n_detout = r_det[WW-1] ? (64'd0 - dval[63:0]) : dval[63:0];
                n_k      = '0;
                n_state  = mi4_pkg::S_O0;
            end
            mi4_pkg::S_O0: n_state = mi4_pkg::S_O1;
            mi4_pkg::S_O1: begin
                if (r_sing) begin
                    n_oelem  = (r_k[3:2] == r_k[1:0]) ? (EW'(1) << FRAC_BITS) : '0;
                    n_osat   = 1'b0;
                    n_ovalid = 1'b1;
                    n_state  = mi4_pkg::S_OUT;
                end else begin
                    n_qneg  = r_cof_rd[WW-1] ^ r_det[WW-1];
                    n_state = mi4_pkg::S_DV;
                end
            end
            mi4_pkg::S_DV: begin
                if (div_done) begin
                    n_oelem  = r_qneg ? (EW'(0) - qval[EW-1:0]) : qval[EW-1:0];
                    n_osat   = qover;
                    n_ovalid = 1'b1;
                    n_state  = mi4_pkg::S_OUT;
                end
            end
            mi4_pkg::S_OUT: begin
                if (!i_stall) begin
                    n_ovalid = 1'b0;
                    n_k      = r_k + 4'd1;
                    n_state  = (r_k == 4'd15) ? mi4_pkg::S_LOAD : mi4_pkg::S_O0;
                end
            end
            default: n_state = mi4_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mi4_pkg::S_LOAD;
            r_load_cnt <= '0;
            r_ovalid   <= 1'b0;
            r_thr      <= 16'd1;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_ovalid   <= n_ovalid;
            if (i_cfg_wr_en)
                r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx   <= n_cidx;
        r_term   <= n_term;
        r_k      <= n_k;
        r_acc    <= n_acc;
        r_det    <= n_det;
        r_magd   <= n_magd;
        r_sing   <= n_sing;
        r_qneg   <= n_qneg;
        r_detout <= n_detout;
        r_x      <= n_x;
        r_oelem  <= n_oelem;
        r_osat   <= n_osat;
    end

    assign o_stall          = (r_state != mi4_pkg::S_LOAD);
    assign o_valid          = r_ovalid;
    assign o_result_element = r_oelem;
    assign o_result_index   = r_k;
    assign o_determinant    = r_detout;
    assign o_singular       = r_sing;
    assign o_saturated      = r_osat;
    assign o_last           = (r_k == 4'd15);
endmodule
`default_nettype wire

/* design/mi4_chk.sv */
// Port-level checks for the matrix inverse, bound to the top level.
`default_nettype none
module mi4_chk #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_stall,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [ELEM_WIDTH-1:0] o_result_element,
    input wire logic [3:0]            o_result_index,
    input wire logic                  o_singular,
    input wire logic                  o_saturated,
    input wire logic                  o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_element))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while results pending");

    a_sing_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> !o_saturated)
        else $error("saturated flag on identity output");

    a_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular && (o_result_index[3:2] == o_result_index[1:0]) |->
        o_result_element == (ELEM_WIDTH'(1) << FRAC_BITS))
        else $error("identity diagonal wrong");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid)
        else $error("result after the last item");
endmodule

bind matrix4_inverse mi4_chk #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_mi4_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_result_element (o_result_element),
    .o_result_index   (o_result_index),
    .o_singular       (o_singular),
    .o_saturated      (o_saturated),
    .o_last           (o_last)
);
`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the 4x4 fixed-point matrix inverse.
`timescale 1ns / 100ps
module testbench;

    typedef logic signed [255:0] t_wide;
    typedef logic [255:0] t_umag;

    typedef struct {
        logic signed [31:0] elem;
        logic [3:0]         idx;
        logic signed [63:0] det;
        logic               sing;
        logic               sat;
        logic               last;
    } t_inv_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_element = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_result_element;
    logic [3:0]         o_result_index;
    logic signed [63:0] o_determinant;
    logic               o_singular;
    logic               o_saturated;
    logic               o_last;
    logic               i_cfg_wr_en = 1'b0;
    logic [15:0]        i_cfg_data = '0;

    matrix4_inverse i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_element(i_element),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_element(o_result_element), .o_result_index(o_result_index),
        .o_determinant(o_determinant), .o_singular(o_singular),
        .o_saturated(o_saturated), .o_last(o_last),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    localparam int WATCHDOG_LIMIT = 150000;
    localparam int RECV_HOLD      = 30000;

    logic signed [31:0] mat_shadow [16];
    int unsigned        load_pos = 0;
    logic [15:0]        sing_thr = 16'd1;
    t_inv_result        inverse_q [$];
    int                 errors = 0;
    int                 hold_left = 0;
    bit                 quiet_sender = 0;
    bit                 quiet_recv = 0;
    int                 idle_cycles = 0;

    function automatic t_wide minor_cof(input int r, input int c);
        int rr [3];
        int cc [3];
        int nr, nc, i;
        t_wide x [3][3];
        t_wide t0, t1, t2, m;
        nr = 0;
        nc = 0;
        for (i = 0; i < 4; i++) begin
            if (i != r) begin rr[nr] = i; nr++; end
            if (i != c) begin cc[nc] = i; nc++; end
        end
        for (int p = 0; p < 3; p++)
            for (int q = 0; q < 3; q++)
                x[p][q] = t_wide'(mat_shadow[rr[p] * 4 + cc[q]]);
        t0 = x[1][1] * x[2][2] - x[1][2] * x[2][1];
        t1 = x[1][0] * x[2][2] - x[1][2] * x[2][0];
        t2 = x[1][0] * x[2][1] - x[1][1] * x[2][0];
        m  = x[0][0] * t0 - x[0][1] * t1 + x[0][2] * t2;
        return ((r + c) % 2) ? -m : m;
    endfunction

    // Clip a magnitude to a signed range of the given width, apply the sign.
    function automatic logic [63:0] clip_signed(input t_umag mag, input logic neg,
                                                input int bits, output logic clipped);
        t_umag lim;
        t_umag v;
        lim = neg ? (t_umag'(1) << (bits - 1)) : ((t_umag'(1) << (bits - 1)) - 1);
        clipped = mag > lim;
        v = clipped ? lim : mag;
        return neg ? -v[63:0] : v[63:0];
    endfunction

    task automatic store_element(input logic signed [31:0] v);
        t_wide       cof [16];
        t_wide       det;
        t_umag       magd, cmag, q;
        logic        dneg, sing, clip, neg;
        logic [63:0] det_out, ev;
        t_inv_result r;
        mat_shadow[load_pos] = v;
        if (load_pos != 15) begin
            load_pos++;
            return;
        end
        load_pos = 0;
        for (int k = 0; k < 16; k++) cof[k] = minor_cof(k / 4, k % 4);
        det = '0;
        for (int j = 0; j < 4; j++) det = det + t_wide'(mat_shadow[j]) * cof[j];
        dneg = det < 0;
        magd = dneg ? -det : det;
        sing = (det == 0) || (magd < (t_umag'(sing_thr) << 48));
        det_out = clip_signed(magd >> 32, dneg, 64, clip);
        for (int k = 0; k < 16; k++) begin
            clip = 1'b0;
            if (sing) begin
                ev = (k / 4 == k % 4) ? 64'h10000 : 64'h0;
            end else begin
                neg  = (cof[(k % 4) * 4 + k / 4] < 0) != dneg;
                cmag = (cof[(k % 4) * 4 + k / 4] < 0) ? -cof[(k % 4) * 4 + k / 4]
                                                       : cof[(k % 4) * 4 + k / 4];
                q  = (cmag << 32) / magd;
                ev = clip_signed(q, neg, 32, clip);
            end
            r.elem = ev[31:0];
            r.idx  = 4'(k);
            r.det  = det_out;
            r.sing = sing;
            r.sat  = clip;
            r.last = (k == 15);
            inverse_q.push_back(r);
        end
    endtask

    task automatic send_element(input logic signed [31:0] v);
        int gap;
        gap = quiet_sender ? 0 :
              (($urandom_range(0, 15) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 2));
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_element = v;
        do @(posedge i_clk); while (o_stall);
        store_element(v);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain_and_set(input logic [15:0] thr);
        while (inverse_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_data  = thr;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sing_thr    = thr;
    endtask

    function automatic logic signed [31:0] small_val(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_random_matrix();
        logic signed [31:0] m [16];
        logic signed [31:0] picks [5];
        int kind;
        picks = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh1, -32'sh1};
        kind = $urandom_range(0, 5);
        for (int k = 0; k < 16; k++) begin
            case (kind)
                0: m[k] = small_val(32'h20000) + ((k / 4 == k % 4) ? 32'sh50000 : 0);
                1: m[k] = $urandom;
                2: m[k] = picks[$urandom_range(0, 4)];
                3: m[k] = small_val(32'h30000);
                4: m[k] = (k / 4 == k % 4) ? $signed($urandom_range(1, 300)) : 0;
                default: m[k] = small_val(64);
            endcase
        end
        if (kind == 3)
            for (int c = 0; c < 4; c++) m[12 + c] = m[c];  // duplicate row, det zero
        for (int k = 0; k < 16; k++) send_element(m[k]);
    endtask

    // Directed rows: identity, all-zero (singular), mixed extremes.
    logic signed [31:0] directed_rows [] = '{
        32'sh10000, 0, 0, 0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
        32'sh7fffffff, 0, 0, 0, 0, 32'sh80000000, 0, 0, 0, 0, 32'sh1, 0, 0, 0, 0, -32'sh1
    };

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (quiet_recv) begin
            i_stall = 1'b0;
        end else begin
            i_stall = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 200) == 0) hold_left = $urandom_range(20, 200);
        end
    end

    always @(posedge i_clk) begin
        t_inv_result e;
        if (o_valid && !i_stall) begin
            if (inverse_q.size() == 0) begin
                $display("%0t: unexpected item idx %0d elem %h", $time,
                         o_result_index, o_result_element);
                errors++;
            end else begin
                e = inverse_q.pop_front();
                if ({o_result_element, o_result_index, o_determinant, o_singular,
                     o_saturated, o_last} !== {e.elem, e.idx, e.det, e.sing, e.sat, e.last}) begin
                    $display("%0t: mismatch exp elem %h idx %0d det %h sing %b sat %b last %b",
                             $time, e.elem, e.idx, e.det, e.sing, e.sat, e.last);
                    $display("%0t:          act elem %h idx %0d det %h sing %b sat %b last %b",
                             $time, o_result_element, o_result_index, o_determinant,
                             o_singular, o_saturated, o_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((o_valid && !i_stall) || (i_valid && !o_stall) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("matrix4_inverse regression: fail");
            $finish;
        end
    end

    initial begin
        logic [15:0] thr_plan [6];
        thr_plan = '{16'd1, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd0};
        thr_plan[3] = $urandom_range(1, 65534);
        thr_plan[4] = $urandom_range(1, 300);
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        quiet_sender = 1;
        quiet_recv   = 1;
        foreach (directed_rows[i]) send_element(directed_rows[i]);
        quiet_sender = 0;
        quiet_recv   = 0;
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_set(thr_plan[ph]);
            if (ph == 2) hold_left = RECV_HOLD;  // block fills and stalls its input
            quiet_sender = (ph == 4);
            quiet_recv   = (ph == 4);
            for (int n = 0; n < ((ph < 2) ? 4 : 3); n++) send_random_matrix();
        end
        while (inverse_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0)
            $display("matrix4_inverse regression: pass");
        else
            $display("matrix4_inverse regression: fail");
        $finish;
    end

endmodule
